FILE: src/wcp_pkg.sv
// ----------------------------------------------------------------------------
// wcp_pkg
// Shared types and constants for the waveform column plotter.
// ----------------------------------------------------------------------------
package wcp_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PIXEL = 2'd1,
        OP_SPAN  = 2'd2
    } op_kind_t;

    // One draw command as it leaves the block.
    typedef struct packed {
        op_kind_t    op_kind;
        logic [7:0]  column;
        logic [6:0]  row_first;
        logic [6:0]  row_last;
        logic [15:0] draw_color;
        logic        last;
    } result_t;

    // Hand-off of one computed item from the input register to the emitter.
    typedef struct packed {
        logic load;
        logic two;
    } load_ctrl_t;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_MODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_QUARTER_SCALE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COLOR   = 2'd2;

    localparam logic [15:0] COLOR_RESET = 16'hFFFF;
    localparam logic [15:0] COLOR_BLACK = 16'h0000;

endpackage

FILE: src/wcp_compute.sv
// ----------------------------------------------------------------------------
// wcp_compute
// Maps one sample to a screen row and builds the one or two draw commands
// it causes, together with the next column and row state.
// ----------------------------------------------------------------------------
module wcp_compute #(
    parameter int COLUMNS = 160,
    parameter int ROWS    = 80,
    parameter int COL_W   = $clog2(COLUMNS),
    parameter int ROW_W   = $clog2(ROWS)
) (
    input  logic [7:0]       sample_value,
    input  logic             line_mode,
    input  logic             quarter_scale,
    input  logic [15:0]      pixel_color,
    input  logic [COL_W-1:0] column_count,
    input  logic [ROW_W-1:0] previous_row,
    output wcp_pkg::result_t first_result,
    output wcp_pkg::result_t second_result,
    output logic             two_results,
    output logic [COL_W-1:0] column_count_next,
    output logic [ROW_W-1:0] previous_row_next
);
    import wcp_pkg::*;

    localparam logic [7:0]       TOP_VALUE = 8'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);

    logic [7:0]       scaled;
    logic [7:0]       clamped;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] row_lo;
    logic [ROW_W-1:0] row_hi;
    logic [ROW_W-1:0] span_first;
    logic [ROW_W-1:0] span_last;
    logic [COL_W-1:0] prev_col;
    logic             frame_start;
    logic             need_span;
    logic [ROW_W+6:0] row_wide;
    logic [ROW_W+6:0] span_first_wide;
    logic [ROW_W+6:0] span_last_wide;
    logic [COL_W+7:0] col_wide;
    logic [COL_W+7:0] prev_col_wide;
    result_t          clear_res;
    result_t          pixel_res;
    result_t          span_res;

    always_comb
    begin
        scaled  = quarter_scale ? {2'b00, sample_value[7:2]} : sample_value;
        clamped = (scaled > TOP_VALUE) ? TOP_VALUE : scaled;
        row     = ROW_W'(TOP_VALUE - clamped);

        frame_start = (column_count == '0);
        prev_col    = column_count - COL_W'(1);

        row_lo     = (row < previous_row) ? row : previous_row;
        row_hi     = (row < previous_row) ? previous_row : row;
        need_span  = ((row_hi - row_lo) > ROW_W'(1));
        span_first = row_lo + ROW_W'(1);
        span_last  = row_hi - ROW_W'(1);

        // Fields are cut or padded to the fixed output widths.
        row_wide        = {7'b0, row};
        span_first_wide = {7'b0, span_first};
        span_last_wide  = {7'b0, span_last};
        col_wide        = {8'b0, column_count};
        prev_col_wide   = {8'b0, prev_col};

        clear_res = '{op_kind: OP_CLEAR, column: 8'd0, row_first: 7'd0,
                      row_last: 7'd0, draw_color: COLOR_BLACK, last: 1'b0};
        pixel_res = '{op_kind: OP_PIXEL, column: col_wide[7:0],
                      row_first: row_wide[6:0], row_last: row_wide[6:0],
                      draw_color: pixel_color, last: 1'b1};
        span_res  = '{op_kind: OP_SPAN, column: prev_col_wide[7:0],
                      row_first: span_first_wide[6:0],
                      row_last: span_last_wide[6:0],
                      draw_color: pixel_color, last: 1'b0};

        if (frame_start)
        begin
            first_result  = clear_res;
            second_result = pixel_res;
            two_results   = !line_mode;
            if (line_mode)
            begin
                first_result.last = 1'b1;
            end
        end
        else if (line_mode && need_span)
        begin
            first_result  = span_res;
            second_result = pixel_res;
            two_results   = 1'b1;
        end
        else
        begin
            first_result  = pixel_res;
            second_result = pixel_res;
            two_results   = 1'b0;
        end

        previous_row_next = row;
        column_count_next = (column_count == LAST_COL) ? '0 : column_count + COL_W'(1);
    end

endmodule

FILE: src/wcp_emitter.sv
// ----------------------------------------------------------------------------
// wcp_emitter
// Two-slot result buffer that presents the draw commands of one item in
// order on the output channel.
// ----------------------------------------------------------------------------
module wcp_emitter (
    input  logic                clk,
    input  logic                rst_n,
    input  wcp_pkg::load_ctrl_t ctrl,
    input  wcp_pkg::result_t    first_result,
    input  wcp_pkg::result_t    second_result,
    input  logic                result_stall,
    output wcp_pkg::result_t    head,
    output logic                head_valid,
    output logic                can_load
);
    import wcp_pkg::*;

    result_t cur_reg;
    result_t nxt_reg;
    logic    cur_valid_reg;
    logic    cur_valid_next;
    logic    nxt_valid_reg;
    logic    nxt_valid_next;
    logic    take;

    assign take       = cur_valid_reg && !result_stall;
    assign can_load   = !cur_valid_reg || (take && !nxt_valid_reg);
    assign head       = cur_reg;
    assign head_valid = cur_valid_reg;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        nxt_valid_next = nxt_valid_reg;
        if (ctrl.load)
        begin
            cur_valid_next = 1'b1;
            nxt_valid_next = ctrl.two;
        end
        else if (take)
        begin
            cur_valid_next = nxt_valid_reg;
            nxt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            nxt_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            nxt_valid_reg <= nxt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cur_reg <= first_result;
            nxt_reg <= second_result;
        end
        else if (take && nxt_valid_reg)
        begin
            cur_reg <= nxt_reg;
        end
    end

endmodule

FILE: src/waveform_column_plotter.sv
// ----------------------------------------------------------------------------
// waveform_column_plotter
// Turns a stream of samples into clear, pixel and vertical span commands
// for a column-by-column line plot.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on sample_valid / sample_stall; an item is taken at an edge
//   where sample_valid is high and sample_stall is low. Draw commands leave
//   on result_valid / result_stall with the same rule, and last marks the
//   final command of each sample.
//   Configuration is written through cfg_valid / cfg_ready (always ready)
//   with cfg_index and cfg_data. The user must write it only while the
//   block is idle; the block itself does not enforce this. Each sample
//   is registered in the input register, then its commands in the result
//   buffer, which shows them. Throughput: one sample per cycle when it
//   yields one command and the receiver does not stall; a sample that
//   yields two keeps the next one in the input register until its second
//   command is shown, as the two-slot result buffer drains one command a cycle.
//   Reset clears the configuration to dot mode, full scale, white, and
//   starts a new frame at column 0 with previous row 0.
//   When the receiver stalls, the current command holds; one more sample
//   waits in the input register and then sample_stall rises.
// ----------------------------------------------------------------------------
module waveform_column_plotter #(
    parameter int COLUMNS = 160,
    parameter int ROWS    = 80
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic [7:0]                         sample_value,
    output logic                               result_valid,
    input  logic                               result_stall,
    output wcp_pkg::op_kind_t                  op_kind,
    output logic [7:0]                         column,
    output logic [6:0]                         row_first,
    output logic [6:0]                         row_last,
    output logic [15:0]                        draw_color,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wcp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [15:0]                        cfg_data
);
    import wcp_pkg::*;

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);

    logic             line_mode_reg;
    logic             quarter_scale_reg;
    logic [15:0]      pixel_color_reg;
    logic [COL_W-1:0] column_count_reg;
    logic [COL_W-1:0] column_count_next;
    logic [ROW_W-1:0] previous_row_reg;
    logic [ROW_W-1:0] previous_row_next;
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       in_sample_reg;
    logic             accept;
    logic             can_load;
    load_ctrl_t       ctrl;
    result_t          first_result;
    result_t          second_result;
    result_t          head;
    logic             two_results;

    assign cfg_ready    = 1'b1;
    assign sample_stall = in_valid_reg && !can_load;
    assign accept       = sample_valid && !sample_stall;
    assign ctrl.load    = in_valid_reg && can_load;
    assign ctrl.two     = two_results;

    wcp_compute #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .COL_W   (COL_W),
        .ROW_W   (ROW_W)
    ) u_compute (
        .sample_value      (in_sample_reg),
        .line_mode         (line_mode_reg),
        .quarter_scale     (quarter_scale_reg),
        .pixel_color       (pixel_color_reg),
        .column_count      (column_count_reg),
        .previous_row      (previous_row_reg),
        .first_result      (first_result),
        .second_result     (second_result),
        .two_results       (two_results),
        .column_count_next (column_count_next),
        .previous_row_next (previous_row_next)
    );

    wcp_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .first_result  (first_result),
        .second_result (second_result),
        .result_stall  (result_stall),
        .head          (head),
        .head_valid    (result_valid),
        .can_load      (can_load)
    );

    assign op_kind    = head.op_kind;
    assign column     = head.column;
    assign row_first  = head.row_first;
    assign row_last   = head.row_last;
    assign draw_color = head.draw_color;
    assign last       = head.last;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (ctrl.load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            column_count_reg  <= '0;
            previous_row_reg  <= '0;
            line_mode_reg     <= 1'b0;
            quarter_scale_reg <= 1'b0;
            pixel_color_reg   <= COLOR_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            // Column and row state advance when the item moves to the buffer.
            if (ctrl.load)
            begin
                column_count_reg <= column_count_next;
                previous_row_reg <= previous_row_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LINE_MODE:     line_mode_reg     <= cfg_data[0];
                    REG_QUARTER_SCALE: quarter_scale_reg <= cfg_data[0];
                    REG_PIXEL_COLOR:   pixel_color_reg   <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_sample_reg <= sample_value;
        end
    end

    // The second command of a sample follows right after the first is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last && !result_stall) |=> result_valid)
        else $error("second command of a sample missing");

    // A clear always carries column zero, row zero and black.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && op_kind == OP_CLEAR) |->
            (column == 8'd0 && row_first == 7'd0 && draw_color == COLOR_BLACK))
        else $error("clear command with nonzero fields");

    // A span is never the final command and always precedes a pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && op_kind == OP_SPAN) |-> !last)
        else $error("span marked as final command");

    // The emitter never takes a new item while the input register is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |-> in_valid_reg)
        else $error("result buffer loaded without an item");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the column plotter. Samples are pushed through the
// input channel under random gaps and receiver stalls, and every draw command
// that comes out is compared field by field with a software copy of the
// plotter held in a scoreboard.
// ----------------------------------------------------------------------------
module tb;

    import wcp_pkg::*;

    localparam int COLUMNS        = 160;
    localparam int ROWS           = 80;
    localparam int PHASE_ITEMS    = 72;
    localparam int RANDOM_PHASES  = 8;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Index past the end of the register list; writes to it are dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    class draw_scoreboard;
        logic        line_mode;
        logic        quarter_scale;
        logic [15:0] pixel_color;
        logic [7:0]  col_next;
        logic [6:0]  prev_row;
        result_t     expected_q[$];
        int          errors;
        int          n_samples;
        int          n_checked;
        int          n_clears;
        int          n_spans;

        function new();
            line_mode     = 1'b0;
            quarter_scale = 1'b0;
            pixel_color   = COLOR_RESET;
            col_next      = '0;
            prev_row      = '0;
            errors        = 0;
            n_samples     = 0;
            n_checked     = 0;
            n_clears      = 0;
            n_spans       = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] data);
            case (idx)
                REG_LINE_MODE:     line_mode     = data[0];
                REG_QUARTER_SCALE: quarter_scale = data[0];
                REG_PIXEL_COLOR:   pixel_color   = data;
                default:           ;
            endcase
        endfunction

        function void push_draw(op_kind_t kind, logic [7:0] col, logic [6:0] r0,
                                logic [6:0] r1, logic [15:0] color, logic fin);
            result_t d;
            d.op_kind    = kind;
            d.column     = col;
            d.row_first  = r0;
            d.row_last   = r1;
            d.draw_color = color;
            d.last       = fin;
            expected_q.push_back(d);
        endfunction

        function void note_sample(logic [7:0] value);
            logic [7:0] height;
            logic [6:0] row;
            logic [6:0] lo;
            logic [6:0] hi;
            height = quarter_scale ? {2'b00, value[7:2]} : value;
            if (height > 8'(ROWS - 1))
                height = 8'(ROWS - 1);
            row = 7'(ROWS - 1) - height[6:0];
            n_samples++;

            // A clear opens every frame; in line mode it is all column 0 gets.
            if (col_next == 0)
            begin
                push_draw(OP_CLEAR, '0, '0, '0, COLOR_BLACK, line_mode);
                n_clears++;
            end
            if (!line_mode)
            begin
                push_draw(OP_PIXEL, col_next, row, row, pixel_color, 1'b1);
            end
            else if (col_next != 0)
            begin
                lo = (row < prev_row) ? row : prev_row;
                hi = (row < prev_row) ? prev_row : row;
                if (hi - lo > 1)
                begin
                    push_draw(OP_SPAN, col_next - 8'd1, lo + 7'd1, hi - 7'd1,
                              pixel_color, 1'b0);
                    n_spans++;
                end
                push_draw(OP_PIXEL, col_next, row, row, pixel_color, 1'b1);
            end

            prev_row = row;
            col_next = (col_next == 8'(COLUMNS - 1)) ? 8'd0 : col_next + 8'd1;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
            if (want !== seen)
            begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("draw command with nothing expected: op_kind %0d column %0d",
                       got.op_kind, got.column);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            compare_field("op_kind",    16'(want.op_kind),   16'(got.op_kind));
            compare_field("column",     16'(want.column),    16'(got.column));
            compare_field("row_first",  16'(want.row_first), 16'(got.row_first));
            compare_field("row_last",   16'(want.row_last),  16'(got.row_last));
            compare_field("draw_color", want.draw_color,     got.draw_color);
            compare_field("last",       16'(want.last),      16'(got.last));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   sample_valid;
    logic                   sample_stall;
    logic [7:0]             sample_value;
    logic                   result_valid;
    logic                   result_stall;
    op_kind_t               op_kind;
    logic [7:0]             column;
    logic [6:0]             row_first;
    logic [6:0]             row_last;
    logic [15:0]            draw_color;
    logic                   last;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [15:0]            cfg_data;

    draw_scoreboard sb = new();

    // Stimulus state; calm, hold_pending and hold_active are shared with the receiver.
    logic       calm;
    logic       burst;
    logic       hold_pending;
    logic       hold_active;
    logic [7:0] prev_sample;
    int         n_settings;

    waveform_column_plotter #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_value (sample_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .op_kind      (op_kind),
        .column       (column),
        .row_first    (row_first),
        .row_last     (row_last),
        .draw_color   (draw_color),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int pick;
        if (calm || burst)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Small steps from the previous sample are the most frequent pick, so that
    // line mode sees row differences of zero, one and two as well as big jumps.
    function automatic logic [7:0] next_sample();
        int pick;
        int level;
        logic [7:0] value;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            value = 8'($urandom);
        end
        else if (pick < 65)
        begin
            level = int'(prev_sample) + $urandom_range(0, 12) - 6;
            if (level < 0)
                level = 0;
            if (level > 255)
                level = 255;
            value = 8'(level);
        end
        else if (pick < 80)
        begin
            case ($urandom_range(0, 5))
                0:       value = 8'd0;
                1:       value = 8'd255;
                2:       value = 8'(ROWS - 1);
                3:       value = 8'(ROWS);
                4:       value = 8'(ROWS - 2);
                default: value = 8'd1;
            endcase
        end
        else
        begin
            value = 8'($urandom_range(0, 90));
        end
        prev_sample = value;
        return value;
    endfunction

    // Valid is left high on return so that a back-to-back item can follow;
    // the caller lowers it after the last item of a run.
    task automatic send_sample(input logic [7:0] value, input int gap);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            sample_value <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_value <= value;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        sb.note_sample(value);
    endtask

    task automatic send_values(input logic [7:0] values[$]);
        foreach (values[i])
            send_sample(values[i], pick_gap());
        sample_valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_sample(next_sample(), pick_gap());
        sample_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_settings();
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_LINE_MODE, 16'($urandom));
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_QUARTER_SCALE, 16'($urandom));
        case ($urandom_range(0, 3))
            0:       write_reg(REG_PIXEL_COLOR, COLOR_BLACK);
            1:       write_reg(REG_PIXEL_COLOR, COLOR_RESET);
            default: write_reg(REG_PIXEL_COLOR, 16'($urandom));
        endcase
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial
    begin : result_receiver
        int hold_len;
        int run_len;
        int pick;
        result_stall = 1'b0;
        hold_active  = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            pick = $urandom_range(0, 99);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_active  = 1'b1;
                hold_len     = LONG_HOLD;
            end
            else if (calm || pick < 25)
                hold_len = 0;
            else if (pick < 80)
                hold_len = $urandom_range(1, 3);
            else if (pick < 95)
                hold_len = $urandom_range(4, 12);
            else
                hold_len = $urandom_range(20, 60);
            if (hold_len > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_active = 1'b0;
            end
            result_stall <= 1'b0;
            run_len = calm ? 8 : $urandom_range(1, 12);
            repeat (run_len) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.op_kind    = op_kind;
            got.column     = column;
            got.row_first  = row_first;
            got.row_last   = row_last;
            got.draw_color = draw_color;
            got.last       = last;
            sb.check_result(got);
        end
    end

    // Any handshake on any channel counts as progress.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (sample_valid && !sample_stall) ||
                (result_valid && !result_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no handshake for %0d cycles, %0d draw commands still expected",
               WATCHDOG_LIMIT, sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] values[$];
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample_value = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        calm         = 1'b0;
        burst        = 1'b0;
        hold_pending = 1'b0;
        prev_sample  = '0;
        n_settings   = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: dot mode, full scale, white. Covers the opening
        // clear, both ends of the range and the clamp to the top row.
        values = '{8'd0, 8'd255, 8'd80, 8'd79, 8'd78, 8'd1, 8'd128, 8'd2};
        send_values(values);
        wait_drained();

        // Line mode in black: full-height spans, equal rows, rows one apart
        // and a one-row span.
        write_reg(REG_LINE_MODE, 16'd1);
        write_reg(REG_PIXEL_COLOR, COLOR_BLACK);
        cfg_valid <= 1'b0;
        n_settings++;
        values = '{8'd0, 8'd255, 8'd254, 8'd78, 8'd76, 8'd79, 8'd0, 8'd1, 8'd3, 8'd200};
        send_values(values);
        wait_drained();

        // Quarter scale, back to dots, and a write past the register list.
        write_reg(REG_QUARTER_SCALE, 16'hFFFF);
        write_reg(REG_LINE_MODE, 16'hFFFE);
        write_reg(REG_PIXEL_COLOR, COLOR_RESET);
        write_reg(REG_UNUSED, 16'h5A5A);
        cfg_valid <= 1'b0;
        n_settings++;
        values = '{8'd255, 8'd3, 8'd4, 8'd252, 8'd0};
        send_values(values);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            random_settings();
            if (phase == 3)
            begin
                calm = 1'b1;
                send_random(PHASE_ITEMS);
                calm = 1'b0;
            end
            else if (phase == 5)
            begin
                // Hold the receiver off and keep offering items back to back so
                // that the block backs up into its input.
                hold_pending = 1'b1;
                wait (hold_active);
                burst = 1'b1;
                send_random(PHASE_ITEMS);
                burst = 1'b0;
            end
            else
            begin
                send_random(PHASE_ITEMS);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d samples under %0d register settings.",
                 sb.n_samples, n_settings);
        $display("Checked %0d draw commands, %0d of them screen clears and %0d spans.",
                 sb.n_checked, sb.n_clears, sb.n_spans);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
